>>> src/fdef_pkg.sv
package fdef_pkg;

  // Field and register widths and frame size limits
  localparam int unsigned PIX_W         = 16;
  localparam int unsigned OUT_W         = 17;
  localparam int unsigned CFG_W         = 10;
  localparam int unsigned ROW_W         = 9;
  localparam int unsigned MAX_HEIGHT    = 512;
  localparam int unsigned DEF_MAX_WIDTH = 512;

  // APB port geometry
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Output queue geometry
  localparam int unsigned OFIFO_DEPTH = 4;
  localparam int unsigned OFIFO_PW    = 2;
  localparam int unsigned OFIFO_CW    = 3;

  // Reset value of both frame dimension registers
  localparam logic [CFG_W-1:0] RESET_DIM = 10'd512;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [OUT_W-1:0] pixel;
    logic             frame_end;
  } res_t;

  // Words handed to the output queue for one accepted input
  typedef struct packed {
    logic edge_vld;
    res_t edge_res;
    logic pass_vld;
    res_t pass_res;
  } push_t;

endpackage

>>> src/forward_difference_edge_filter_top.sv
// Forward-difference edge filter, L1 gradient magnitude.
// Input channel: one grey pixel per word (pixel_in_i), raster order, on
// in_valid_i / in_ready_o. Output channel: pixel_out_o and frame_end_o on
// out_valid_o / out_ready_i, also raster order, delayed by one image row.
// Frame size comes from two APB registers: frame_width at 0x0 and
// frame_height at 0x4; any write restarts the frame at row 0, column 0.
// A row 0 word gives no output; a middle-row word gives the finished pixel
// above it; a last-row word gives the pixel above and then itself unchanged.
// Every output word is held in the output queue before it leaves.
// Throughput: one pixel per cycle in all rows but the last while the output
// queue has room, set by the line chain that shifts once per accepted pixel;
// in the last row each pixel makes two words, so the single output port sets the pace.
// A four-word output queue decouples the sides: input keeps flowing while a
// word waits, and in_ready_o drops only when the queue cannot take the words
// of the next pixel, so a stalled receiver holds everything without loss.
// Reset clears counters and queue and sets both registers to 512; the line
// chain is not cleared, row 0 of each frame fills it.
module forward_difference_edge_filter_top #(
  parameter int unsigned MAX_WIDTH = fdef_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // APB configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fdef_pkg::APB_AW-1:0]    paddr,
  input  logic [fdef_pkg::APB_DW-1:0]    pwdata,
  output logic [fdef_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  // Pixel input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fdef_pkg::PIX_W-1:0]     pixel_in_i,
  // Result output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fdef_pkg::OUT_W-1:0]     pixel_out_o,
  output logic                           frame_end_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WSW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EXT_W = (WSW > fdef_pkg::CFG_W) ? WSW : fdef_pkg::CFG_W;
  localparam int unsigned FW    = fdef_pkg::CFG_W;
  localparam int unsigned QCW   = fdef_pkg::OFIFO_CW;

  logic [FW-1:0]               fw_q, fw_d;
  logic [FW-1:0]               fh_q, fh_d;
  logic [CW-1:0]               col_q, col_d;
  logic [fdef_pkg::ROW_W-1:0]  row_q, row_d;

  logic                        cfg_wr;
  fdef_pkg::reg_idx_e          cfg_idx;
  logic [EXT_W-1:0]            fw_ext;
  logic [WSW-1:0]              wsat;
  logic [FW-1:0]               hsat;
  logic [WSW-1:0]              inj_idx;
  logic                        last_col;
  logic                        last_row;
  logic                        in_acc;
  logic [1:0]                  need;
  logic [QCW-1:0]              q_cnt;
  logic                        q_pop;
  fdef_pkg::push_t             push;
  fdef_pkg::res_t              head;
  logic [fdef_pkg::OUT_W-1:0]  edge_val;
  logic [fdef_pkg::PIX_W-1:0]  line_w [MAX_WIDTH];

  // Configuration decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = fdef_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    fw_d = fw_q;
    fh_d = fh_q;
    if (cfg_wr) begin
      case (cfg_idx)
        fdef_pkg::REG_FRAME_WIDTH:  fw_d = pwdata[FW-1:0];
        fdef_pkg::REG_FRAME_HEIGHT: fh_d = pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      fdef_pkg::REG_FRAME_WIDTH:  prdata = fdef_pkg::APB_DW'(fw_q);
      fdef_pkg::REG_FRAME_HEIGHT: prdata = fdef_pkg::APB_DW'(fh_q);
      default:                    prdata = '0;
    endcase
  end

  // Clamp frame dimensions to their usable range
  assign fw_ext = EXT_W'(fw_q);

  always_comb begin
    if (fw_ext == '0) begin
      wsat = WSW'(1);
    end else if (fw_ext > EXT_W'(MAX_WIDTH)) begin
      wsat = WSW'(MAX_WIDTH);
    end else begin
      wsat = WSW'(fw_ext);
    end
  end

  always_comb begin
    if (fh_q == '0) begin
      hsat = FW'(1);
    end else if (fh_q > FW'(fdef_pkg::MAX_HEIGHT)) begin
      hsat = FW'(fdef_pkg::MAX_HEIGHT);
    end else begin
      hsat = fh_q;
    end
  end

  // Position flags of the incoming pixel
  assign last_col = ((WSW'(col_q) + WSW'(1)) == wsat);
  assign last_row = ((FW'(row_q) + FW'(1)) == hsat);
  assign inj_idx  = WSW'(MAX_WIDTH) - wsat;

  // Accept only when the queue has room for all words of this pixel
  assign need       = {1'b0, (row_q != '0)} + {1'b0, last_row};
  assign in_ready_o = ((q_cnt + QCW'(need)) <= QCW'(fdef_pkg::OFIFO_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;

  // Line chain: a pixel enters wsat places from the end, so the last cell
  // holds the pixel above and the one before it the pixel above-right
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_line
    if (i == 0) begin : g_first
      fdef_cell u_cell (
        .clk_i    (clk_i),
        .shift_i  (in_acc),
        .inject_i (inj_idx == WSW'(i)),
        .pix_i    (pixel_in_i),
        .prev_i   (pixel_in_i),
        .pix_o    (line_w[i])
      );
    end else begin : g_rest
      fdef_cell u_cell (
        .clk_i    (clk_i),
        .shift_i  (in_acc),
        .inject_i (inj_idx == WSW'(i)),
        .pix_i    (pixel_in_i),
        .prev_i   (line_w[i-1]),
        .pix_o    (line_w[i])
      );
    end
  end

  // Edge value of the pixel above
  fdef_grad u_grad (
    .pix_i       (pixel_in_i),
    .above_i     (line_w[MAX_WIDTH-1]),
    .right_i     (line_w[MAX_WIDTH-2]),
    .has_right_i (!last_col),
    .edge_o      (edge_val)
  );

  // Build the words for the output queue
  always_comb begin
    push.edge_vld           = in_acc && (row_q != '0);
    push.edge_res.pixel     = edge_val;
    push.edge_res.frame_end = 1'b0;
    push.pass_vld           = in_acc && last_row;
    push.pass_res.pixel     = {1'b0, pixel_in_i};
    push.pass_res.frame_end = last_col;
  end

  assign q_pop = out_valid_o && out_ready_i;

  fdef_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_pop),
    .cnt_o   (q_cnt),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign pixel_out_o = head.pixel;
  assign frame_end_o = head.frame_end;

  // Advance raster position; restart the frame on any register write
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : (row_q + fdef_pkg::ROW_W'(1));
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= fdef_pkg::RESET_DIM;
      fh_q  <= fdef_pkg::RESET_DIM;
      col_q <= '0;
      row_q <= '0;
    end else begin
      fw_q  <= fw_d;
      fh_q  <= fh_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_col && last_row) |=> ((col_q == '0) && (row_q == '0)))
    else $error("position did not wrap at frame end");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WSW'(col_q) < wsat)
    else $error("column left the frame");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FW'(row_q) < hsat)
    else $error("row left the frame");

endmodule

>>> src/fdef_cell.sv
module fdef_cell (
  input  logic                      clk_i,
  input  logic                      shift_i,
  input  logic                      inject_i,
  input  logic [fdef_pkg::PIX_W-1:0] pix_i,
  input  logic [fdef_pkg::PIX_W-1:0] prev_i,
  output logic [fdef_pkg::PIX_W-1:0] pix_o
);

  logic [fdef_pkg::PIX_W-1:0] pix_q;
  logic [fdef_pkg::PIX_W-1:0] pix_d;

  // Take the new pixel at the entry point, else the left neighbor
  assign pix_d = inject_i ? pix_i : prev_i;

  // Advance one place per accepted word
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

>>> src/fdef_grad.sv
module fdef_grad (
  input  logic [fdef_pkg::PIX_W-1:0] pix_i,
  input  logic [fdef_pkg::PIX_W-1:0] above_i,
  input  logic [fdef_pkg::PIX_W-1:0] right_i,
  input  logic                       has_right_i,
  output logic [fdef_pkg::OUT_W-1:0] edge_o
);

  logic [fdef_pkg::PIX_W-1:0] diff_v;
  logic [fdef_pkg::PIX_W-1:0] diff_h;

  // Vertical difference: pixel below against the pixel above it
  assign diff_v = (pix_i > above_i) ? (pix_i - above_i) : (above_i - pix_i);

  // Horizontal difference: right neighbor against the same pixel
  assign diff_h = (right_i > above_i) ? (right_i - above_i) : (above_i - right_i);

  // Sum both, or pass the pixel in the last column
  always_comb begin
    if (has_right_i) begin
      edge_o = {1'b0, diff_v} + {1'b0, diff_h};
    end else begin
      edge_o = {1'b0, above_i};
    end
  end

endmodule

>>> src/fdef_ofifo.sv
module fdef_ofifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fdef_pkg::push_t                  push_i,
  input  logic                             pop_i,
  output logic [fdef_pkg::OFIFO_CW-1:0]    cnt_o,
  output logic                             valid_o,
  output fdef_pkg::res_t                   head_o
);

  localparam int unsigned PW = fdef_pkg::OFIFO_PW;
  localparam int unsigned CW = fdef_pkg::OFIFO_CW;

  fdef_pkg::res_t mem_q [fdef_pkg::OFIFO_DEPTH];
  logic [PW-1:0]  wr_q, wr_d;
  logic [PW-1:0]  rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  npush;
  logic [PW-1:0]  pass_addr;

  assign npush     = CW'(push_i.edge_vld) + CW'(push_i.pass_vld);
  assign pass_addr = push_i.edge_vld ? (wr_q + PW'(1)) : wr_q;

  // Store the edge word first, the pass-through word after it
  always_ff @(posedge clk_i) begin
    if (push_i.edge_vld) begin
      mem_q[wr_q] <= push_i.edge_res;
    end
    if (push_i.pass_vld) begin
      mem_q[pass_addr] <= push_i.pass_res;
    end
  end

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q + npush[PW-1:0];
    rd_d  = rd_q + PW'(pop_i);
    cnt_d = cnt_q + npush - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o   = cnt_q;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(fdef_pkg::OFIFO_DEPTH))
    else $error("output queue overfilled");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (cnt_q == $past(cnt_q) + $past(npush) - CW'($past(pop_i))))
    else $error("output queue count lost a word");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("pop from empty output queue");

endmodule
